FILE: rtl/lgs_pkg.sv
// shared types, constants and helpers for the life generation stream
package lgs_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int MIN_SIZE = 3;

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int CFG_W   = 11;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;
  localparam int SUM_W   = 4;

  // register index taken from paddr[2]
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // line buffer entry: bit 1 upper line, bit 0 middle line
  typedef logic [1:0] lb_entry_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    lb_entry_t        data;
  } lb_wr_t;

  function automatic logic [1:0] pop3(input logic [2:0] v);
    pop3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
  endfunction

endpackage

FILE: rtl/life_generation_stream.sv
// top level: streaming game of life (B3/S23) next-generation engine
//
// input channel: one grid cell per word in raster order (cell_alive_i),
// in_valid_i / in_stall_o; a word is taken when valid is high and stall low
// output channel: next_alive_o with out_row_o / out_col_o / frame_last_o,
// out_valid_o / out_stall_i; cell (r-1, c-1) is sent when cell (r, c) arrives,
// so the first row and column of input words produce no output word
// path: an input word reaches the output through the line buffer read stage,
// then the window/rule stage into the output register
// throughput: one cell per cycle while the receiver does not stall; the line
// buffer memory does one read and one write per cycle and the 3x3 window
// shifts through a chain of two column cells plus the incoming column
// outer ring of the grid is forced dead, first row/column emit dead cells
// config: grid_rows at address 0, grid_cols at address 4 (apb, pready always
// high); any write restarts the generation at row 0, column 0
// reset: counters and window cleared, grid 3x3; line buffers need no clear,
// every entry is written before it can reach a non-border result
// a stalled receiver holds the output register; the input side keeps
// accepting until the pipeline stage behind it is full
module life_generation_stream (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lgs_pkg::PADDR_W-1:0] paddr,
  input  logic [lgs_pkg::DATA_W-1:0]  pwdata,
  output logic [lgs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // cell input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cell_alive_i,
  // next state output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        next_alive_o,
  output logic [lgs_pkg::ROW_W-1:0]   out_row_o,
  output logic [lgs_pkg::COL_W-1:0]   out_col_o,
  output logic                        frame_last_o
);

  localparam int CW = lgs_pkg::CFG_W;
  localparam int RW = lgs_pkg::ROW_W;
  localparam int KW = lgs_pkg::COL_W;
  localparam int SW = lgs_pkg::SUM_W;

  // stage 1 payload, beside the registered line buffer read
  typedef struct packed {
    logic          emit;   // r >= 1 and c >= 1
    logic          full;   // r >= 2 and c >= 2, neighborhood is real
    logic          last;   // last emitted cell of the generation
    logic          bot;    // incoming cell after border masking
    logic [KW-1:0] addr;   // column of the incoming cell
    logic [RW-1:0] orow;
    logic [KW-1:0] ocol;
  } s1_t;

  // config registers
  logic [CW-1:0] grid_rows_q, grid_cols_q;
  logic          cfg_wr;

  // raster counters
  logic [RW-1:0] row_q, row_d;
  logic [KW-1:0] col_q, col_d;

  // pipeline
  logic          s1_valid_q;
  s1_t           s1_q, s1_d;
  logic          s1_adv, in_acc;

  logic          out_valid_q;
  logic          next_q, last_q;
  logic [RW-1:0] orow_q;
  logic [KW-1:0] ocol_q;

  // --------------------------------------------------------------------
  // config port
  // --------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= CW'(lgs_pkg::MIN_SIZE);
      grid_cols_q <= CW'(lgs_pkg::MIN_SIZE);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lgs_pkg::REG_GRID_ROWS: grid_rows_q <= pwdata[CW-1:0];
        lgs_pkg::REG_GRID_COLS: grid_cols_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      lgs_pkg::REG_GRID_ROWS: prdata[CW-1:0] = grid_rows_q;
      lgs_pkg::REG_GRID_COLS: prdata[CW-1:0] = grid_cols_q;
      default: ;
    endcase
  end

  // clamp sizes to [3, max] and keep the index of the last row/column
  logic [CW-1:0] rows_eff, cols_eff, rows_m1, cols_m1;
  logic [RW-1:0] rows_last;
  logic [KW-1:0] cols_last;

  always_comb begin
    if (grid_rows_q < CW'(lgs_pkg::MIN_SIZE)) begin
      rows_eff = CW'(lgs_pkg::MIN_SIZE);
    end else if (grid_rows_q > CW'(lgs_pkg::MAX_ROWS)) begin
      rows_eff = CW'(lgs_pkg::MAX_ROWS);
    end else begin
      rows_eff = grid_rows_q;
    end
    if (grid_cols_q < CW'(lgs_pkg::MIN_SIZE)) begin
      cols_eff = CW'(lgs_pkg::MIN_SIZE);
    end else if (grid_cols_q > CW'(lgs_pkg::MAX_COLS)) begin
      cols_eff = CW'(lgs_pkg::MAX_COLS);
    end else begin
      cols_eff = grid_cols_q;
    end
    rows_m1   = rows_eff - CW'(1);
    cols_m1   = cols_eff - CW'(1);
    rows_last = rows_m1[RW-1:0];
    cols_last = cols_m1[KW-1:0];
  end

  // --------------------------------------------------------------------
  // stage 0: raster position, border mask, line buffer read
  // --------------------------------------------------------------------
  logic [RW-1:0] r;
  logic [KW-1:0] c;
  logic          border;

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    // out-of-range position wraps to the start of a generation
    if (row_q > rows_last || col_q > cols_last) begin
      r = '0;
      c = '0;
    end else begin
      r = row_q;
      c = col_q;
    end
    border = (r == '0) | (r == rows_last) | (c == '0) | (c == cols_last);

    s1_d.emit = (r != '0) & (c != '0);
    s1_d.full = (r > RW'(1)) & (c > KW'(1));
    s1_d.last = (r == rows_last) & (c == cols_last);
    s1_d.bot  = cell_alive_i & ~border;
    s1_d.addr = c;
    s1_d.orow = r - RW'(1);
    s1_d.ocol = c - KW'(1);

    if (c == cols_last) begin
      col_d = '0;
      row_d = (r == rows_last) ? '0 : r + RW'(1);
    end else begin
      col_d = c + KW'(1);
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // line buffers: read at accept, write back the shifted column as the
  // word leaves stage 1 (consecutive words never share a column)
  lgs_pkg::lb_entry_t lb_rd;
  lgs_pkg::lb_wr_t    lb_wr;

  assign lb_wr.en   = s1_adv;
  assign lb_wr.addr = s1_q.addr;
  assign lb_wr.data = {lb_rd[0], s1_q.bot};

  lgs_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (c),
    .rd_data_o (lb_rd),
    .wr_i      (lb_wr)
  );

  // --------------------------------------------------------------------
  // stage 1: window chain and rule
  // --------------------------------------------------------------------
  logic [2:0]    newcol, col_a, col_b;
  logic [SW-1:0] sum_new, sum_a, sum_b, nbrs;
  logic          center, next_s1;

  // bit 0 top, bit 1 middle, bit 2 incoming row
  assign newcol  = {s1_q.bot, lb_rd[0], lb_rd[1]};
  assign sum_new = SW'(lgs_pkg::pop3(newcol));

  // newest previous column
  lgs_col_cell u_cell_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .col_i   (newcol),
    .sum_i   (sum_new),
    .col_o   (col_a),
    .sum_o   (sum_a)
  );

  // oldest column
  lgs_col_cell u_cell_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .col_i   (col_a),
    .sum_i   (sum_a),
    .col_o   (col_b),
    .sum_o   (sum_b)
  );

  // the center cell sits in the middle of the newest previous column
  assign center  = col_a[1];
  assign nbrs    = sum_b - SW'(center);
  assign next_s1 = s1_q.full & ((nbrs == SW'(3)) | ((nbrs == SW'(2)) & center));

  // --------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_q.emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.emit) begin
      next_q <= next_s1;
      last_q <= s1_q.last;
      orow_q <= s1_q.orow;
      ocol_q <= s1_q.ocol;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = next_q;
  assign out_row_o    = orow_q;
  assign out_col_o    = ocol_q;
  assign frame_last_o = last_q;

endmodule

FILE: rtl/lgs_line_buf.sv
// two one-bit line buffers packed in one memory, registered read
module lgs_line_buf (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [lgs_pkg::COL_W-1:0] rd_addr_i,
  output lgs_pkg::lb_entry_t        rd_data_o,
  input  lgs_pkg::lb_wr_t           wr_i
);

  lgs_pkg::lb_entry_t mem [lgs_pkg::MAX_COLS];
  lgs_pkg::lb_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/lgs_col_cell.sv
// one window column cell: holds a 3-cell column, adds its live count to the chain sum
module lgs_col_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic [2:0]                col_i,
  input  logic [lgs_pkg::SUM_W-1:0] sum_i,
  output logic [2:0]                col_o,
  output logic [lgs_pkg::SUM_W-1:0] sum_o
);

  logic [2:0] col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;
  assign sum_o = sum_i + lgs_pkg::SUM_W'(lgs_pkg::pop3(col_q));

endmodule
